/* rtl/core/tce_pkg.sv */
// Shared constants, codes and controller/datapath interface types for the text console.
package tce_pkg;

    localparam int COLUMNS_DEF = 80;
    localparam int ROWS_DEF    = 25;

    localparam logic [7:0] BLANK_CHAR   = 8'h20;
    localparam logic [7:0] RESET_ATTR   = 8'h17;
    localparam logic [7:0] CH_NEWLINE   = 8'd10;
    localparam logic [7:0] CH_TAB       = 8'd9;
    localparam logic [7:0] CH_BACKSPACE = 8'd8;

    localparam logic KIND_PUT  = 1'b0;
    localparam logic KIND_READ = 1'b1;

    localparam int TAB_SPACES = 4;
    localparam int TAB_W      = $clog2(TAB_SPACES);

    localparam int S_DATA_W = 24;  // char_code, cell_index
    localparam int M_DATA_W = 40;  // cell_char, cell_attr, cursor_col, cursor_row, cursor_offset

    typedef struct packed {
        logic accept;       // word taken on the slave side
        logic clr_step;     // one cell of the power-up clear
        logic put_write;    // write latched char at cursor
        logic scroll_step;  // one cell of the scroll walk
        logic finish;       // load the result register
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic scroll_last;
        logic pending;      // cursor on the row past the screen
        logic tab_last;
        logic out_free;
        logic in_read;
        logic in_newline;
        logic nl_scroll;
    } t_stat;

endpackage

/* rtl/core/tce_ctrl.sv */
// Controller state machine for the text console.
module tce_ctrl
    import tce_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_s_tvalid,
    output logic  o_s_tready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_PUT    = 3'd2;
    localparam logic [2:0] S_SCROLL = 3'd3;
    localparam logic [2:0] S_DONE   = 3'd4;

    logic [2:0] r_state, n_state;
    logic       r_ret_put, n_ret_put;

    assign o_s_tready = (r_state == S_IDLE);

    always_comb begin
        n_state   = r_state;
        n_ret_put = r_ret_put;
        o_cmd     = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.accept = 1'b1;
                    if (i_stat.in_read) begin
                        n_state = S_DONE;
                    end else if (i_stat.in_newline) begin
                        n_ret_put = 1'b0;
                        n_state   = i_stat.nl_scroll ? S_SCROLL : S_DONE;
                    end else begin
                        n_state = S_PUT;
                    end
                end
            end
            S_PUT: begin
                if (i_stat.pending) begin
                    n_ret_put = 1'b1;
                    n_state   = S_SCROLL;
                end else begin
                    o_cmd.put_write = 1'b1;
                    if (i_stat.tab_last) begin
                        n_state = S_DONE;
                    end
                end
            end
            S_SCROLL: begin
                o_cmd.scroll_step = 1'b1;
                if (i_stat.scroll_last) begin
                    n_state = r_ret_put ? S_PUT : S_DONE;
                end
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_ret_put <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_ret_put <= n_ret_put;
        end
    end

endmodule

/* rtl/core/tce_datapath.sv */
// Screen memory, cursor, attribute register and result register of the text console.
module tce_datapath
    import tce_pkg::*;
#(
    parameter int COLUMNS = COLUMNS_DEF,
    parameter int ROWS    = ROWS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cmd                i_cmd,
    output t_stat               o_stat,
    input  logic [S_DATA_W-1:0] i_s_tdata,
    input  logic                i_s_tuser,
    input  logic                i_cfg_we,
    input  logic [7:0]          i_cfg_wdata,
    input  logic                i_m_tready,
    output logic                o_m_tvalid,
    output logic [M_DATA_W-1:0] o_m_tdata
);

    localparam int CELLS = COLUMNS * ROWS;
    localparam int AW    = $clog2(CELLS);
    localparam int CW    = $clog2(COLUMNS);
    localparam int RW    = $clog2(ROWS + 1);
    localparam int NW    = $clog2(CELLS + 1);
    localparam int OW    = $clog2(CELLS + 1);
    localparam int SW    = $clog2(CELLS + COLUMNS + 1);

    logic [15:0]         mem [CELLS];
    logic [15:0]         r_rdata;
    logic [7:0]          r_cfg;
    logic [CW-1:0]       r_col, n_col;
    logic [RW-1:0]       r_row, n_row;
    logic [NW-1:0]       r_cnt;
    logic [TAB_W-1:0]    r_tabs;
    logic                r_adv;
    logic [7:0]          r_wch;
    logic                r_is_rd;
    logic                r_out_valid;
    logic [M_DATA_W-1:0] r_out_data;

    logic [7:0]     in_char;
    logic [10:0]    in_idx;
    logic           in_read;
    logic           idx_ok;
    logic [AW+10:0] idx_ext;
    logic [OW-1:0]  off;
    logic [OW+10:0] off_ext;
    logic [CW+6:0]  col_ext;
    logic [RW+4:0]  row_ext;
    logic [NW-1:0]  cnt_m1;
    logic [SW-1:0]  src;
    logic           src_ok;
    logic           w_en, rd_en;
    logic [AW-1:0]  w_addr, rd_addr;
    logic [15:0]    w_data;
    logic [7:0]     res_char, res_attr;

    assign in_char = i_s_tdata[7:0];
    assign in_idx  = i_s_tdata[18:8];
    assign in_read = (i_s_tuser == KIND_READ);
    assign idx_ok  = 32'(in_idx) < 32'(CELLS);
    assign idx_ext = {{AW{1'b0}}, in_idx};

    assign off     = OW'(r_row) * OW'(COLUMNS) + OW'(r_col);
    assign off_ext = {11'b0, off};
    assign col_ext = {7'b0, r_col};
    assign row_ext = {5'b0, r_row};

    assign cnt_m1 = r_cnt - NW'(1);
    assign src    = SW'(r_cnt) + SW'(COLUMNS);
    assign src_ok = src < SW'(CELLS);

    assign o_stat.clr_last    = (r_cnt == NW'(CELLS - 1));
    assign o_stat.scroll_last = (r_cnt == NW'(CELLS));
    assign o_stat.pending     = (r_row == RW'(ROWS));
    assign o_stat.tab_last    = (r_tabs == '0);
    assign o_stat.out_free    = !r_out_valid || i_m_tready;
    assign o_stat.in_read     = in_read;
    assign o_stat.in_newline  = (in_char == CH_NEWLINE);
    assign o_stat.nl_scroll   = (r_row >= RW'(ROWS - 1));

    // cursor update
    always_comb begin
        n_col = r_col;
        n_row = r_row;
        priority if (i_cmd.accept && !in_read) begin
            if (in_char == CH_NEWLINE) begin
                n_col = '0;
                if (r_row != RW'(ROWS)) begin
                    n_row = RW'(r_row + 1'b1);
                end
            end else if (in_char == CH_BACKSPACE) begin
                if (r_col == '0) begin
                    if (r_row != '0) begin
                        n_row = RW'(r_row - 1'b1);
                        n_col = CW'(COLUMNS - 1);
                    end
                end else begin
                    n_col = CW'(r_col - 1'b1);
                end
            end
        end else if (i_cmd.put_write && r_adv) begin
            if (r_col == CW'(COLUMNS - 1)) begin
                n_col = '0;
                n_row = RW'(r_row + 1'b1);
            end else begin
                n_col = CW'(r_col + 1'b1);
            end
        end else if (i_cmd.scroll_step && o_stat.scroll_last) begin
            n_col = '0;
            n_row = RW'(ROWS - 1);
        end else begin
            n_col = r_col;
        end
    end

    // memory port selection
    always_comb begin
        w_en    = 1'b0;
        w_addr  = r_cnt[AW-1:0];
        w_data  = {RESET_ATTR, BLANK_CHAR};
        rd_en   = 1'b0;
        rd_addr = src[AW-1:0];
        if (i_cmd.clr_step) begin
            w_en = 1'b1;
        end
        if (i_cmd.put_write) begin
            w_en   = 1'b1;
            w_addr = off[AW-1:0];
            w_data = {r_cfg, r_wch};
        end
        if (i_cmd.scroll_step) begin
            w_en   = (r_cnt != '0);
            w_addr = cnt_m1[AW-1:0];
            w_data = (cnt_m1 < NW'(CELLS - COLUMNS)) ? r_rdata : {r_cfg, BLANK_CHAR};
            rd_en  = src_ok;
        end
        if (i_cmd.accept && in_read) begin
            rd_en   = idx_ok;
            rd_addr = idx_ext[AW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            mem[w_addr] <= w_data;
        end
        if (rd_en) begin
            r_rdata <= mem[rd_addr];
        end
    end

    assign res_char = r_is_rd ? r_rdata[7:0]  : 8'h00;
    assign res_attr = r_is_rd ? r_rdata[15:8] : 8'h00;

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_wch <= (in_char == CH_BACKSPACE || in_char == CH_TAB) ? BLANK_CHAR : in_char;
        end
        if (i_cmd.finish) begin
            r_out_data <= {1'b0, off_ext[10:0], row_ext[4:0], col_ext[6:0], res_attr, res_char};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg       <= RESET_ATTR;
            r_col       <= '0;
            r_row       <= '0;
            r_cnt       <= '0;
            r_tabs      <= '0;
            r_adv       <= 1'b0;
            r_is_rd     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
            if (i_cfg_we) begin
                r_cfg <= i_cfg_wdata;
            end
            if (i_cmd.clr_step) begin
                r_cnt <= o_stat.clr_last ? '0 : NW'(r_cnt + 1'b1);
            end else if (i_cmd.scroll_step) begin
                r_cnt <= o_stat.scroll_last ? '0 : NW'(r_cnt + 1'b1);
            end
            if (i_cmd.accept) begin
                r_adv   <= (in_char != CH_BACKSPACE);
                r_tabs  <= (in_char == CH_TAB) ? TAB_W'(TAB_SPACES - 1) : '0;
                r_is_rd <= in_read && idx_ok;
            end else if (i_cmd.put_write && r_tabs != '0) begin
                r_tabs <= TAB_W'(r_tabs - 1'b1);
            end
            if (i_cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    a_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_row <= RW'(ROWS))
        else $error("cursor row beyond pending row");

    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_col <= CW'(COLUMNS - 1))
        else $error("cursor column beyond last column");

    a_pending_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_row == RW'(ROWS)) |-> (r_col == '0))
        else $error("pending scroll with nonzero column");

    a_scroll_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.scroll_step && o_stat.scroll_last) |=>
            (r_row == RW'(ROWS - 1) && r_col == '0 && r_cnt == '0))
        else $error("scroll did not leave cursor on last row");

endmodule

/* rtl/core/text_console_engine.sv */
// Top level of the text console: controller plus screen datapath.
// Text console of COLUMNS x ROWS character cells. A read word goes straight to the result
// stage, a newline only moves the cursor and may scroll, and a plain character, backspace or
// tab first writes its cells in the put state (a tab writes TAB_SPACES cells). A scroll walks
// every cell of the single-write-port screen memory, which moves one cell per cycle. After
// reset the block runs a clearing pass through the screen memory and accepts no word until
// it ends; attribute writes are taken at any time. The next word is accepted while a result
// still waits on the master side.
module text_console_engine
    import tce_pkg::*;
#(
    parameter int COLUMNS = COLUMNS_DEF,
    parameter int ROWS    = ROWS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [S_DATA_W-1:0] s_axis_tdata,   // char_code[7:0], cell_index[18:8], zero pad
    input  logic                s_axis_tuser,   // kind
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [M_DATA_W-1:0] m_axis_tdata,   // cell_char, cell_attr, cursor_col,
                                                // cursor_row, cursor_offset, zero pad
    input  logic                i_cfg_we,
    input  logic [7:0]          i_cfg_wdata     // cell_attribute
);

    t_cmd  cmd;
    t_stat stat;

    tce_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    tce_datapath #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_s_tdata   (s_axis_tdata),
        .i_s_tuser   (s_axis_tuser),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_m_tready  (m_axis_tready),
        .o_m_tvalid  (m_axis_tvalid),
        .o_m_tdata   (m_axis_tdata)
    );

endmodule
